// ===== rtl/lsma_pkg.sv =====
// ============================================================================
// lsma_pkg : shared types and constants for lidar sector minimum avoidance
// Widths, register indexes, reset values, drive action codes and the
// structs passed between the block's modules.
// ============================================================================
package lsma_pkg;

  // Field widths
  localparam int DistW    = 16;
  localparam int SpeedW   = 12;
  localparam int CmdW     = 13;
  localparam int AngleW   = 9;
  localparam int RegIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 32;  // angle_index + range_mm, padded to bytes
  localparam int OutDataW = 32;  // action + linear_cmd + angular_cmd, padded

  // Register reset values
  localparam logic [DistW-1:0]  MaxRangeRst    = 16'd3500;
  localparam logic [DistW-1:0]  CrashDistRst   = 16'd250;
  localparam logic [DistW-1:0]  BehindClearRst = 16'd1000;
  localparam logic [DistW-1:0]  StopDistRst    = 16'd150;
  localparam logic [DistW-1:0]  TestDistRst    = 16'd400;
  localparam logic [SpeedW-1:0] LinSpeedRst    = 12'd300;
  localparam logic [SpeedW-1:0] AngSpeedRst    = 12'd1500;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_MAX_RANGE     = 3'd0,
    REG_CRASH_DIST    = 3'd1,
    REG_BEHIND_CLEAR  = 3'd2,
    REG_STOP_DIST     = 3'd3,
    REG_TEST_DIST     = 3'd4,
    REG_LINEAR_SPEED  = 3'd5,
    REG_ANGULAR_SPEED = 3'd6
  } reg_idx_t;

  // Drive actions
  typedef enum logic [2:0] {
    ACT_FORWARD    = 3'd0,
    ACT_TURN_LEFT  = 3'd1,
    ACT_TURN_RIGHT = 3'd2,
    ACT_BACKWARD   = 3'd3,
    ACT_STOP       = 3'd4
  } action_t;

  // Item kinds (carried on tuser)
  localparam logic ModeSample = 1'b0;
  localparam logic ModeTick   = 1'b1;

  // Configuration register bank
  typedef struct packed {
    logic [DistW-1:0]  max_range;
    logic [DistW-1:0]  crash_dist;
    logic [DistW-1:0]  behind_clear;
    logic [DistW-1:0]  stop_dist;
    logic [DistW-1:0]  test_dist;
    logic [SpeedW-1:0] linear_speed;
    logic [SpeedW-1:0] angular_speed;
  } cfg_t;

  // One input item as held in the input register
  typedef struct packed {
    logic              mode;
    logic [AngleW-1:0] angle;
    logic [DistW-1:0]  range;
    logic              last;
  } item_t;

  // Committed scan results seen by the drive decision
  typedef struct packed {
    logic [DistW-1:0] front;
    logic [DistW-1:0] fleft;
    logic [DistW-1:0] fright;
    logic             crash;
  } scan_stat_t;

  // Drive decision
  typedef struct packed {
    logic                   valid;
    action_t                action;
    logic signed [CmdW-1:0] linear;
    logic signed [CmdW-1:0] angular;
  } drive_t;

endpackage

// ===== rtl/lsma_cfg.sv =====
// ============================================================================
// lsma_cfg : configuration register bank
// Seven write-only registers, written by index on cfg_we.
// ============================================================================
module lsma_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lsma_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [lsma_pkg::CfgDataW-1:0] cfg_wdata,
  output lsma_pkg::cfg_t                cfg
);

  lsma_pkg::cfg_t cfg_r;
  lsma_pkg::cfg_t cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lsma_pkg::REG_MAX_RANGE:     cfg_nxt.max_range     = cfg_wdata;
        lsma_pkg::REG_CRASH_DIST:    cfg_nxt.crash_dist    = cfg_wdata;
        lsma_pkg::REG_BEHIND_CLEAR:  cfg_nxt.behind_clear  = cfg_wdata;
        lsma_pkg::REG_STOP_DIST:     cfg_nxt.stop_dist     = cfg_wdata;
        lsma_pkg::REG_TEST_DIST:     cfg_nxt.test_dist     = cfg_wdata;
        lsma_pkg::REG_LINEAR_SPEED:
          cfg_nxt.linear_speed  = cfg_wdata[lsma_pkg::SpeedW-1:0];
        lsma_pkg::REG_ANGULAR_SPEED:
          cfg_nxt.angular_speed = cfg_wdata[lsma_pkg::SpeedW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_range     <= lsma_pkg::MaxRangeRst;
      cfg_r.crash_dist    <= lsma_pkg::CrashDistRst;
      cfg_r.behind_clear  <= lsma_pkg::BehindClearRst;
      cfg_r.stop_dist     <= lsma_pkg::StopDistRst;
      cfg_r.test_dist     <= lsma_pkg::TestDistRst;
      cfg_r.linear_speed  <= lsma_pkg::LinSpeedRst;
      cfg_r.angular_speed <= lsma_pkg::AngSpeedRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lsma_sector.sv =====
// ============================================================================
// lsma_sector : sector minimum tracking and scan commit
// Decodes the beam angle to a sector, keeps six running minima, and on the
// last sample of a scan commits the front minima and updates the crash flag.
// ============================================================================
module lsma_sector (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsma_pkg::cfg_t       cfg,
  input  logic                 sample_en,
  input  lsma_pkg::item_t      item,
  output lsma_pkg::scan_stat_t stat
);

  typedef enum logic [2:0] {
    SEC_FRONT  = 3'd0,
    SEC_FLEFT  = 3'd1,
    SEC_LEFT   = 3'd2,
    SEC_RIGHT  = 3'd3,
    SEC_FRIGHT = 3'd4,
    SEC_BEHIND = 3'd5,
    SEC_NONE   = 3'd6
  } sector_t;

  localparam int NumSec = 6;

  sector_t                    sec;
  logic [lsma_pkg::DistW-1:0] min_r   [NumSec];
  logic [lsma_pkg::DistW-1:0] min_nxt [NumSec];
  logic [lsma_pkg::DistW-1:0] cand    [NumSec];
  lsma_pkg::scan_stat_t       stat_r;
  lsma_pkg::scan_stat_t       stat_nxt;
  logic                       near;

  // Angle to sector
  always_comb begin
    if (item.angle inside {[9'd0:9'd29], [9'd330:9'd359]}) sec = SEC_FRONT;
    else if (item.angle inside {[9'd30:9'd59]})            sec = SEC_FLEFT;
    else if (item.angle inside {[9'd60:9'd89]})            sec = SEC_LEFT;
    else if (item.angle inside {[9'd90:9'd269]})           sec = SEC_BEHIND;
    else if (item.angle inside {[9'd270:9'd299]})          sec = SEC_RIGHT;
    else if (item.angle inside {[9'd300:9'd329]})          sec = SEC_FRIGHT;
    else                                                   sec = SEC_NONE;
  end

  // Candidate minima including this sample; zero range is no return
  always_comb begin
    for (int i = 0; i < NumSec; i++) begin
      cand[i] = min_r[i];
      if (item.range != '0 && sec == sector_t'(3'(i)) && item.range < min_r[i]) begin
        cand[i] = item.range;
      end
    end
  end

  assign near = (cand[SEC_FRONT]  < cfg.crash_dist) ||
                (cand[SEC_FRIGHT] < cfg.crash_dist) ||
                (cand[SEC_RIGHT]  < cfg.crash_dist);

  // Minima update and commit on last sample
  always_comb begin
    stat_nxt = stat_r;
    for (int i = 0; i < NumSec; i++) begin
      min_nxt[i] = min_r[i];
    end
    if (sample_en) begin
      for (int i = 0; i < NumSec; i++) begin
        min_nxt[i] = item.last ? cfg.max_range : cand[i];
      end
      if (item.last) begin
        stat_nxt.front  = cand[SEC_FRONT];
        stat_nxt.fleft  = cand[SEC_FLEFT];
        stat_nxt.fright = cand[SEC_FRIGHT];
        if (!near) begin
          stat_nxt.crash = 1'b0;
        end else if (cand[SEC_BEHIND] > cfg.behind_clear) begin
          stat_nxt.crash = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumSec; i++) begin
        min_r[i] <= lsma_pkg::MaxRangeRst;
      end
      stat_r <= '0;
    end else begin
      for (int i = 0; i < NumSec; i++) begin
        min_r[i] <= min_nxt[i];
      end
      stat_r <= stat_nxt;
    end
  end

  assign stat = stat_r;

endmodule

// ===== rtl/lsma_drive.sv =====
// ============================================================================
// lsma_drive : drive command decision
// Chooses stop, backward, forward or a turn from the committed minima and
// the crash flag; an exact tie with the test distance gives no command unless stop or backward applies.
// ============================================================================
module lsma_drive (
  input  lsma_pkg::cfg_t       cfg,
  input  lsma_pkg::scan_stat_t stat,
  output lsma_pkg::drive_t     drive
);

  logic signed [lsma_pkg::CmdW-1:0] lin_pos;
  logic signed [lsma_pkg::CmdW-1:0] ang_pos;
  logic                             tie;

  assign lin_pos = $signed({1'b0, cfg.linear_speed});
  assign ang_pos = $signed({1'b0, cfg.angular_speed});
  assign tie = (stat.front == cfg.test_dist) || (stat.fleft == cfg.test_dist) ||
               (stat.fright == cfg.test_dist);

  // Priority decision
  always_comb begin
    drive.valid   = 1'b1;
    drive.action  = lsma_pkg::ACT_STOP;
    drive.linear  = '0;
    drive.angular = '0;
    if (!(stat.front > cfg.stop_dist)) begin
      drive.action = lsma_pkg::ACT_STOP;
    end else if (stat.crash) begin
      drive.action = lsma_pkg::ACT_BACKWARD;
      drive.linear = -lin_pos;
    end else if (tie) begin
      drive.valid = 1'b0;
    end else if (stat.front > cfg.test_dist && stat.fleft > cfg.test_dist &&
                 stat.fright > cfg.test_dist) begin
      drive.action = lsma_pkg::ACT_FORWARD;
      drive.linear = lin_pos;
    end else if (stat.fleft < cfg.test_dist && stat.fright > cfg.test_dist) begin
      drive.action  = lsma_pkg::ACT_TURN_RIGHT;
      drive.angular = -ang_pos;
    end else begin
      drive.action  = lsma_pkg::ACT_TURN_LEFT;
      drive.angular = ang_pos;
    end
  end

endmodule

// ===== rtl/lidar_sector_min_avoidance.sv =====
// ============================================================================
// lidar_sector_min_avoidance : lidar sector minimum obstacle avoidance
// Tracks per-sector minimum lidar ranges and issues drive commands on ticks.
// ============================================================================
//
//  Channel  Direction  Beat contents
//  -------  ---------  ----------------------------------------------------
//  in_      slave      tdata: angle_index, range_mm; tuser: mode;
//                      tlast: last_sample
//  out_     master     tdata: action, linear_cmd, angular_cmd
//  cfg_     write      cfg_index selects register, cfg_wdata value
//
//  One beat per cycle unless a tick stalls: input register, combinational
//  sector/decision logic, then the result register, which drives out_.
//  Reset (synchronous, rst_n low) restores register defaults, restarts
//  the minima at 3500 and clears committed state. A tick stalls in the
//  input register only while the result register is full and out_tready
//  is low; samples never stall.
//
module lidar_sector_min_avoidance (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lsma_pkg::InDataW-1:0]  in_tdata,   // [8:0] angle_index, [24:9] range_mm
  input  logic                          in_tuser,   // [0] mode
  input  logic                          in_tlast,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lsma_pkg::OutDataW-1:0] out_tdata,  // [2:0] action, [15:3] linear_cmd,
                                                    // [28:16] angular_cmd
  // configuration
  input  logic                          cfg_we,
  input  logic [lsma_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [lsma_pkg::CfgDataW-1:0] cfg_wdata
);

  lsma_pkg::cfg_t       cfg;
  lsma_pkg::scan_stat_t stat;
  lsma_pkg::drive_t     drive;

  logic                 in_valid_r;
  logic                 in_valid_nxt;
  lsma_pkg::item_t      item_r;
  lsma_pkg::item_t      item_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  lsma_pkg::drive_t     res_r;
  lsma_pkg::drive_t     res_nxt;

  logic                 out_free;
  logic                 advance;
  logic                 fire;
  logic                 sample_en;
  logic                 emit;
  logic                 in_accept;

  lsma_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsma_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .sample_en (sample_en),
    .item      (item_r),
    .stat      (stat)
  );

  lsma_drive u_drive (
    .cfg   (cfg),
    .stat  (stat),
    .drive (drive)
  );

  // Flow control: a tick needs room in the result register
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = !in_valid_r || (item_r.mode == lsma_pkg::ModeSample) || out_free;
  assign in_tready = advance;
  assign in_accept = in_tvalid && in_tready;
  assign fire      = in_valid_r && advance;
  assign sample_en = fire && (item_r.mode == lsma_pkg::ModeSample);
  assign emit      = fire && (item_r.mode == lsma_pkg::ModeTick) && drive.valid;

  // Input register
  always_comb begin
    in_valid_nxt = in_accept || (in_valid_r && !advance);
    item_nxt     = item_r;
    if (in_accept) begin
      item_nxt.mode  = in_tuser;
      item_nxt.angle = in_tdata[lsma_pkg::AngleW-1:0];
      item_nxt.range = in_tdata[lsma_pkg::AngleW +: lsma_pkg::DistW];
      item_nxt.last  = in_tlast;
    end
  end

  // Result register
  always_comb begin
    res_nxt = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = drive;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.angular, res_r.linear, res_r.action};

endmodule
